[design/double_ended_queue_assert.svh]
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared property forms for the deque checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, disabled while in reset.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// Deque package
// Command codes, cell operations and shared constants of the deque.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;

    // Answer for a pop or peek on an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5,
        CMD_QUERY      = 3'd6
    } deq_cmd_e;

    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,
        OP_SHIFT_IN  = 2'd1,
        OP_SHIFT_OUT = 2'd2,
        OP_WRITE_AT  = 2'd3
    } deq_op_e;

    typedef struct packed {
        deq_op_e                  op;
        logic signed [DATA_W-1:0] value;
    } deq_ctl_t;

endpackage

[design/deq_if.sv]
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for requests and results of the deque.
// ----------------------------------------------------------------------------
interface deq_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic signed [31:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface deq_out_if #(
    parameter int CNT_W = 9
);
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]   entry_count;
    logic               is_empty;
    logic               push_dropped;

    modport source (
        output valid, output read_value, output entry_count,
        output is_empty, output push_dropped, input ready
    );
    modport sink (
        input valid, input read_value, input entry_count,
        input is_empty, input push_dropped, output ready
    );
endinterface

[design/deq_cell.sv]
// ----------------------------------------------------------------------------
// Deque cell
// One storage entry of a chain: holds, shifts from a neighbor or is written.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
#(
    parameter int CNT_W = 9,
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  deq_ctl_t                 ctl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] lower,
    input  logic signed [DATA_W-1:0] upper,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            OP_HOLD:      data_next = data_reg;
            OP_SHIFT_IN:  data_next = lower;
            OP_SHIFT_OUT: data_next = upper;
            OP_WRITE_AT:
            begin
                // only the cell just past the last held entry takes the value
                if (count == CNT_W'(INDEX))
                begin
                    data_next = ctl.value;
                end
            end
            default:      data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[design/deq_chain.sv]
// ----------------------------------------------------------------------------
// Deque cell chain
// Row of cells with its end entry at cell 0; shifts toward or away from it.
// ----------------------------------------------------------------------------
module deq_chain
    import deq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int CNT_W = 9
) (
    input  logic                     clk,
    input  deq_ctl_t                 ctl,
    input  logic [CNT_W-1:0]         count,
    output logic signed [DATA_W-1:0] head
);

    logic signed [DATA_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] lower_w;
        logic signed [DATA_W-1:0] upper_w;

        if (i == 0)
        begin : g_first
            assign lower_w = ctl.value;
        end
        else
        begin : g_inner_lo
            assign lower_w = cell_data[i-1];
        end

        // the last cell lies beyond any held entry after a shift out
        if (i == DEPTH - 1)
        begin : g_last
            assign upper_w = cell_data[i];
        end
        else
        begin : g_inner_hi
            assign upper_w = cell_data[i+1];
        end

        deq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .count (count),
            .lower (lower_w),
            .upper (upper_w),
            .data  (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// Double-ended queue
// Deque of signed 32-bit values built from two mirrored chains of cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (command, push_value); each yields one result on rsp
// (read_value, entry_count, is_empty, push_dropped). The rsp interface must be
// instantiated with CNT_W = $clog2(DEPTH + 1).
// One chain keeps the front entry at its cell 0, the other keeps the back
// entry at its cell 0, so every read comes from a fixed cell. A push at one
// end shifts that end's chain and writes the other chain at the cell indexed
// by the entry count; a pop shifts only its own chain.
// The result is registered and shows in the cycle after the request
// is taken. Throughput: one request per cycle while rsp is not stalled,
// set by the single result register. A push to a full queue is dropped
// and flagged; a pop or peek on an empty queue answers -1.
// When rsp stalls, the result holds and req.ready drops until it is taken.
// Reset empties the queue at once; cell contents are not cleared and are
// never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic signed [DATA_W-1:0] read_value_reg;
    logic signed [DATA_W-1:0] read_value_next;
    logic [CNT_W-1:0]         entry_count_reg;
    logic                     is_empty_reg;
    logic                     push_dropped_reg;
    logic                     push_dropped_next;

    deq_ctl_t                 front_ctl;
    deq_ctl_t                 back_ctl;
    logic signed [DATA_W-1:0] front_head;
    logic signed [DATA_W-1:0] back_head;
    logic                     accept;
    logic                     full;
    logic                     empty;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        front_ctl.op      = OP_HOLD;
        front_ctl.value   = req.push_value;
        back_ctl.op       = OP_HOLD;
        back_ctl.value    = req.push_value;
        count_next        = count_reg;
        read_value_next   = '0;
        push_dropped_next = 1'b0;

        if (accept)
        begin
            unique case (deq_cmd_e'(req.command))
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        push_dropped_next = 1'b1;
                    end
                    else
                    begin
                        back_ctl.op  = OP_SHIFT_IN;
                        front_ctl.op = OP_WRITE_AT;
                        count_next   = count_reg + 1'b1;
                    end
                end
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        push_dropped_next = 1'b1;
                    end
                    else
                    begin
                        front_ctl.op = OP_SHIFT_IN;
                        back_ctl.op  = OP_WRITE_AT;
                        count_next   = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        read_value_next = EMPTY_VALUE;
                    end
                    else
                    begin
                        read_value_next = front_head;
                        front_ctl.op    = OP_SHIFT_OUT;
                        count_next      = count_reg - 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        read_value_next = EMPTY_VALUE;
                    end
                    else
                    begin
                        read_value_next = back_head;
                        back_ctl.op     = OP_SHIFT_OUT;
                        count_next      = count_reg - 1'b1;
                    end
                end
                CMD_PEEK_FRONT:
                begin
                    read_value_next = empty ? EMPTY_VALUE : front_head;
                end
                CMD_PEEK_BACK:
                begin
                    read_value_next = empty ? EMPTY_VALUE : back_head;
                end
                CMD_QUERY:
                begin
                    read_value_next = '0;
                end
                default:
                begin
                    // unused code behaves as a query
                    read_value_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_front_chain (
        .clk   (clk),
        .ctl   (front_ctl),
        .count (count_reg),
        .head  (front_head)
    );

    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_back_chain (
        .clk   (clk),
        .ctl   (back_ctl),
        .count (count_reg),
        .head  (back_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg   <= read_value_next;
            entry_count_reg  <= count_next;
            is_empty_reg     <= (count_next == '0);
            push_dropped_reg <= push_dropped_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_value   = read_value_reg;
    assign rsp.entry_count  = entry_count_reg;
    assign rsp.is_empty     = is_empty_reg;
    assign rsp.push_dropped = push_dropped_reg;

endmodule

[design/deq_checker.sv]
// ----------------------------------------------------------------------------
// Deque port checker
// Port-level checks of the deque, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_checker #(
    parameter int DEPTH = 256,
    parameter int CNT_W = 9
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic signed [31:0] rsp_read_value,
    input logic [CNT_W-1:0]   rsp_entry_count,
    input logic               rsp_is_empty,
    input logic               rsp_push_dropped
);

    logic               rsp_stall;
    logic               rsp_full;
    logic [CNT_W+33:0]  rsp_payload;

    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign rsp_full    = (rsp_entry_count == CNT_W'(DEPTH));
    assign rsp_payload = {rsp_read_value, rsp_entry_count, rsp_is_empty, rsp_push_dropped};

    // a stalled result keeps its contents
    `DEQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp_payload))

    // every request taken produces a result in the next cycle
    `DEQ_ASSERT_NEXT(a_req_to_rsp, clk, rst_n, req_valid && req_ready, rsp_valid)

    `DEQ_ASSERT_NOW(a_empty_flag, clk, rst_n, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))

    // a dropped push only happens with a full queue
    `DEQ_ASSERT_NOW(a_drop_full, clk, rst_n, rsp_valid && rsp_push_dropped, rsp_full)

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
) u_deq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_read_value   (rsp.read_value),
    .rsp_entry_count  (rsp.entry_count),
    .rsp_is_empty     (rsp.is_empty),
    .rsp_push_dropped (rsp.push_dropped)
);
